>>> design/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define KMP_ASSERT_NEVER(label, cond, msg) \
  `KMP_ASSERT(label, !(cond), msg)

`endif

>>> design/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW     = 5;
  localparam int unsigned StartW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } kmp_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_text;
    logic       last_of_text;
  } kmp_in_t;

  typedef struct packed {
    logic              match_now;
    logic [StartW-1:0] match_start;
    logic              no_match_at_end;
  } kmp_out_t;

  typedef struct packed {
    logic step;
    logic clear;
  } kmp_ctl_t;

endpackage

`default_nettype wire

>>> design/kmp_cell.sv
`default_nettype none

module kmp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmp_pkg::kmp_ctl_t ctl_i,
  input  logic              pat_we_i,
  input  logic [7:0]        pat_byte_i,
  input  logic [7:0]        text_byte_i,
  input  logic              prev_i,
  output logic              hit_o,
  output logic              active_o
);
  import kmp_pkg::*;

  logic [7:0] pat_q;
  logic       active_q, active_d;

  assign hit_o    = prev_i && (pat_q == text_byte_i);
  assign active_o = active_q;

  always_comb begin
    active_d = active_q;
    if (ctl_i.clear) begin
      active_d = 1'b0;
    end else if (ctl_i.step) begin
      active_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q    <= '0;
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (pat_we_i) begin
        pat_q <= pat_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/kmp_pattern_search.sv
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   in_data_i   (text_byte, first, last)
// out       out  out_valid_o / out_ready_i out_data_o  (match_now, start, no_match)
// cfg       in   cfg_we_i                  cfg_index_i, cfg_data_i
//
// One transaction per cycle unless out stalls: the cell row compares every pattern
// position with the incoming byte in the same cycle, and the result lands in one
// output register; in_ready_o is high while that register is empty or being
// drained. A stalled output holds the cell row and the offset counter. Reset loads
// the all-zero pattern of length one; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module kmp_pattern_search #(
  parameter int unsigned MAX_PATTERN  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  kmp_pkg::kmp_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kmp_pkg::kmp_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [kmp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [kmp_pkg::CfgDataW-1:0]        cfg_data_i
);
  import kmp_pkg::*;

  localparam int unsigned IdxW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned DiffW = (OFFSET_WIDTH > StartW) ? OFFSET_WIDTH : StartW;

  logic                    accept;
  logic                    cfg_hit;
  kmp_ctl_t                ctl;
  logic [MAX_PATTERN-1:0]  hit, active, prev;
  logic [IdxW-1:0]         len_m1_q, len_m1_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d, here;
  logic                    found_q, found_d, found_eff;
  logic                    out_valid_q, out_valid_d;
  kmp_out_t                out_q, out_d;
  logic                    match;
  logic [DiffW-1:0]        diff;
  logic [6:0]              len_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign cfg_hit    = cfg_we_i && ((cfg_index_i == REG_PAT_LOW) ||
                                   (cfg_index_i == REG_PAT_HIGH) ||
                                   (cfg_index_i == REG_PAT_LEN));
  assign ctl.step   = accept;
  assign ctl.clear  = cfg_hit;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic       pat_we;
    logic [7:0] pat_byte;
    if (i == 0) begin : g_head
      assign prev[i] = 1'b1;
    end else begin : g_link
      assign prev[i] = active[i-1] && !in_data_i.first_of_text;
    end
    if (i < 8) begin : g_low
      assign pat_we   = cfg_we_i && (cfg_index_i == REG_PAT_LOW);
      assign pat_byte = cfg_data_i[8*(i%8) +: 8];
    end else if (i < 16) begin : g_high
      assign pat_we   = cfg_we_i && (cfg_index_i == REG_PAT_HIGH);
      assign pat_byte = cfg_data_i[8*(i%8) +: 8];
    end else begin : g_none
      assign pat_we   = 1'b0;
      assign pat_byte = 8'h00;
    end
    kmp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .pat_we_i    (pat_we),
      .pat_byte_i  (pat_byte),
      .text_byte_i (in_data_i.text_byte),
      .prev_i      (prev[i]),
      .hit_o       (hit[i]),
      .active_o    (active[i])
    );
  end

  // length register stored as clamped length minus one
  always_comb begin
    len_ext  = {2'b00, cfg_data_i[LenW-1:0]};
    len_m1_d = len_m1_q;
    if (cfg_we_i && (cfg_index_i == REG_PAT_LEN)) begin
      if (len_ext == 7'd0) begin
        len_m1_d = '0;
      end else if (len_ext > 7'(MAX_PATTERN)) begin
        len_m1_d = IdxW'(MAX_PATTERN - 1);
      end else begin
        len_m1_d = IdxW'(len_ext - 7'd1);
      end
    end
  end

  always_comb begin
    here      = in_data_i.first_of_text ? '0 : offset_q;
    found_eff = found_q && !in_data_i.first_of_text;
    match     = hit[len_m1_q] && !found_eff;
    diff      = DiffW'(here) - DiffW'(len_m1_q);

    offset_d    = offset_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      offset_d    = (&here) ? here : here + OFFSET_WIDTH'(1);
      found_d     = found_eff || match;
      out_valid_d = 1'b1;
      out_d.match_now       = match;
      out_d.match_start     = match ? diff[StartW-1:0] : '0;
      out_d.no_match_at_end = in_data_i.last_of_text && !found_eff && !match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q    <= '0;
      offset_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_m1_q    <= len_m1_d;
      offset_q    <= offset_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KMP_ASSERT_NEVER(a_excl_flags, out_valid_q && out_q.match_now && out_q.no_match_at_end, "match and no-match together")
  `KMP_ASSERT(a_found_rise, !found_q ##1 found_q |-> out_valid_q && out_q.match_now, "found set without a match result")
  `KMP_ASSERT(a_match_found, out_valid_q && out_q.match_now |-> found_q, "match reported but search not marked done")

endmodule

`default_nettype wire

>>> dv/tb_kmp_pattern_search.sv
`timescale 1ns / 1ps

module tb_kmp_pattern_search;
  import kmp_pkg::*;

  localparam int unsigned ITEMS_TOTAL = 1550;
  localparam int unsigned PAT_MAX     = 16;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  kmp_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  kmp_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  kmp_pattern_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // search model state
  logic [CfgDataW-1:0] pat_lo, pat_hi;
  logic [LenW-1:0]     pat_len_q;
  logic [7:0]          pat_byte [PAT_MAX];
  logic [LenW-1:0]     fail_len [PAT_MAX];
  int unsigned         eff_len;
  logic [LenW-1:0]     run_len;
  logic [StartW-1:0]   text_pos;
  logic                hit_seen;

  kmp_out_t exp_results [$];

  // stimulus-side view of the current pattern
  logic [7:0]  cur_pat [PAT_MAX];
  int unsigned cur_len;
  logic [7:0]  alpha [4];
  int unsigned alpha_n;

  bit no_idle = 1'b0;
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_matches = 0, n_misses = 0, n_writes = 0;

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic void rebuild_table();
    int k;
    for (int i = 0; i < PAT_MAX; i++) begin
      pat_byte[i] = (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
      fail_len[i] = '0;
    end
    if (pat_len_q == 0) eff_len = 1;
    else if (pat_len_q > PAT_MAX) eff_len = PAT_MAX;
    else eff_len = pat_len_q;
    k = 0;
    for (int i = 1; i < eff_len; i++) begin
      while (k > 0 && pat_byte[i] != pat_byte[k]) k = fail_len[k-1];
      if (pat_byte[i] == pat_byte[k]) k++;
      fail_len[i] = LenW'(k);
    end
    run_len = '0;
  endfunction

  function automatic void reset_search_model();
    pat_lo    = '0;
    pat_hi    = '0;
    pat_len_q = 5'd1;
    text_pos  = '0;
    hit_seen  = 1'b0;
    rebuild_table();
  endfunction

  function automatic void apply_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      REG_PAT_LOW:  pat_lo = val;
      REG_PAT_HIGH: pat_hi = val;
      REG_PAT_LEN:  pat_len_q = val[LenW-1:0];
      default:      return;
    endcase
    rebuild_table();
  endfunction

  function automatic kmp_out_t predict_search(kmp_in_t item);
    kmp_out_t res;
    logic [StartW-1:0] here;
    int m;
    res = '0;
    if (item.first_of_text) begin
      run_len  = '0;
      text_pos = '0;
      hit_seen = 1'b0;
    end
    here = text_pos;
    if (!hit_seen) begin
      m = run_len;
      if (m >= eff_len) m = 0;
      while (m > 0 && pat_byte[m] != item.text_byte) m = fail_len[m-1];
      if (pat_byte[m] == item.text_byte) m++;
      if (m >= eff_len) begin
        res.match_now   = 1'b1;
        res.match_start = here - StartW'(eff_len - 1);
        hit_seen        = 1'b1;
        m               = 0;
      end
      run_len = LenW'(m);
      if (item.last_of_text && !hit_seen) res.no_match_at_end = 1'b1;
    end
    if (text_pos != '1) text_pos++;
    return res;
  endfunction

  // called at a rising edge; returns at the edge where the transaction happens
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    kmp_in_t item;
    int gap;
    logic ok;
    item.text_byte     = b;
    item.first_of_text = f;
    item.last_of_text  = l;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      ok = in_ready_o;
      @(posedge clk_i);
    end while (!ok);
    exp_results.push_back(predict_search(item));
    n_sent++;
  endtask

  task automatic stop_and_drain();
    in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_config(idx, val);
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_pattern(input logic [127:0] bits, input logic [LenW-1:0] len);
    logic [CfgDataW-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    len_word[LenW-1:0] = len;
    write_reg(REG_PAT_LOW, bits[63:0]);
    write_reg(REG_PAT_HIGH, bits[127:64]);
    write_reg(REG_PAT_LEN, len_word);
    for (int j = 0; j < PAT_MAX; j++) cur_pat[j] = bits[8*j +: 8];
    if (len == 0) cur_len = 1;
    else if (len > PAT_MAX) cur_len = PAT_MAX;
    else cur_len = len;
  endtask

  task automatic report_field(input string name, input logic [StartW-1:0] want,
                              input logic [StartW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side
  initial begin
    kmp_out_t want;
    int stall;
    logic fire;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        fire = out_valid_o;
        if (fire) begin
          if (exp_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
          end else begin
            want = exp_results.pop_front();
            report_field("match_now", want.match_now, out_data_o.match_now);
            report_field("match_start", want.match_start, out_data_o.match_start);
            report_field("no_match_at_end", want.no_match_at_end, out_data_o.no_match_at_end);
            n_checked++;
            if (want.match_now) n_matches++;
            if (want.no_match_at_end) n_misses++;
          end
        end
        @(posedge clk_i);
      end while (!fire);
    end
  end

  task automatic test_reset_pattern();
    send_byte(8'h41, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    stop_and_drain();
  endtask

  task automatic test_continuation();
    send_byte(8'h41, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    stop_and_drain();
  endtask

  task automatic test_overlap();
    logic [7:0] txt [7];
    txt = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h43};
    set_pattern(128'h43_42_41_42_41, 5'd5);
    no_idle = 1'b1;
    for (int i = 0; i < 7; i++) send_byte(txt[i], i == 0, i == 6);
    stop_and_drain();
    no_idle = 1'b0;
  endtask

  task automatic test_length_limits();
    set_pattern(128'hFF, 5'd0);
    send_byte(8'hFF, 1'b1, 1'b1);
    stop_and_drain();
    write_reg(REG_UNUSED, '1);
    send_byte(8'h00, 1'b1, 1'b1);
    stop_and_drain();
    set_pattern('1, 5'd31);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    stop_and_drain();
  endtask

  task automatic test_reconfig_mid_text();
    set_pattern(128'h42_41, 5'd2);
    send_byte(8'h41, 1'b1, 1'b0);
    stop_and_drain();
    // partial match is dropped, offset keeps counting
    write_reg(REG_PAT_LEN, 64'd2);
    send_byte(8'h42, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h42, 1'b0, 1'b1);
    stop_and_drain();
  endtask

  task automatic random_pattern();
    logic [127:0] bits;
    logic [LenW-1:0] len;
    alpha_n = $urandom_range(1, 4);
    for (int j = 0; j < 4; j++) alpha[j] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      for (int j = 0; j < PAT_MAX; j++) bits[8*j +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
    end
    case ($urandom_range(0, 19))
      0:       len = 5'd1;
      1:       len = 5'd16;
      2:       len = 5'd0;
      3:       len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(1, 16));
    endcase
    set_pattern(bits, len);
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, {$urandom(), $urandom()});
  endtask

  task automatic random_text();
    logic [7:0] txt [$];
    logic [CfgDataW-1:0] word;
    int tl, pos;
    bit has_first, has_last, split;
    logic f, l;
    tl = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 40));
    for (int i = 0; i < tl; i++) begin
      if ($urandom_range(0, 6) == 0) txt.push_back(8'($urandom_range(0, 255)));
      else txt.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
    end
    if ($urandom_range(0, 1) == 1) begin
      pos = $urandom_range(0, tl - 1);
      for (int j = 0; j < cur_len; j++) begin
        if (pos + j < txt.size()) txt[pos + j] = cur_pat[j];
        else txt.push_back(cur_pat[j]);
      end
    end
    has_first = $urandom_range(0, 9) != 0;
    has_last  = $urandom_range(0, 9) != 0;
    split     = txt.size() > 2 && $urandom_range(0, 9) == 0;
    for (int i = 0; i < txt.size(); i++) begin
      if (split && i == txt.size() / 2) begin
        stop_and_drain();
        word = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0) begin
          write_reg(REG_UNUSED, word);
        end else begin
          word[LenW-1:0] = LenW'(cur_len);
          write_reg(REG_PAT_LEN, word);
        end
      end
      f = (i == 0 && has_first) || $urandom_range(0, 39) == 0;
      l = (i == txt.size() - 1 && has_last) || $urandom_range(0, 39) == 0;
      send_byte(txt[i], f, l);
    end
  endtask

  task automatic test_random();
    int ntexts;
    while (n_sent < ITEMS_TOTAL) begin
      no_idle = $urandom_range(0, 3) == 0;
      random_pattern();
      ntexts = $urandom_range(2, 6);
      repeat (ntexts) random_text();
      stop_and_drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_search_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_continuation();
    test_overlap();
    test_length_limits();
    test_reconfig_mid_text();
    test_random();
    stop_and_drain();
    $display("sent %0d text bytes, checked %0d results (%0d first matches, %0d misses at end)",
             n_sent, n_checked, n_matches, n_misses);
    $display("%0d register writes over lengths 0 to 31, with and without handshake stalls",
             n_writes);
    if (errors == 0) begin
      $display("tb_kmp_pattern_search OK");
    end else begin
      $display("tb_kmp_pattern_search NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", exp_results.size());
    $display("tb_kmp_pattern_search NOT OK");
    $finish;
  end

endmodule
